FILE: rtl/core/fsfs_pkg.sv
// Shared types and constants for the framebuffer shape fill scanner.
// No dependencies; imported by framebuffer_shape_fill_scanner.
`default_nettype none

package fsfs_pkg;

   // Result field widths
   localparam int PIXEL_INDEX_W = 20;
   localparam int PIXEL_X_W     = 10;
   localparam int PIXEL_Y_W     = 9;
   localparam int COLOR_W       = 32;

   // Stream payload widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 72;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Configuration register widths
   localparam int MODE_W   = 2;
   localparam int ORIGIN_W = 12;
   localparam int SIZE_W   = 11;
   localparam int RADIUS_W = 10;

   // Signed geometry width: covers pixel positions, shape edges and distances
   localparam int GEOM_W = 15;
   localparam int SQ_W   = 2 * GEOM_W;
   localparam int RSQ_W  = 2 * RADIUS_W;

   typedef enum logic [MODE_W-1:0] {
      SHAPE_RECT    = 2'd0,
      SHAPE_CIRCLE  = 2'd1,
      SHAPE_ROUNDED = 2'd2
   } shape_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SHAPE_MODE    = 3'd0,
      REG_FILL_COLOR    = 3'd1,
      REG_ORIGIN_X      = 3'd2,
      REG_ORIGIN_Y      = 3'd3,
      REG_BOX_WIDTH     = 3'd4,
      REG_BOX_HEIGHT    = 3'd5,
      REG_CORNER_RADIUS = 3'd6,
      REG_BUFFER_SELECT = 3'd7
   } csr_reg_type;

endpackage

`default_nettype wire

FILE: rtl/core/framebuffer_shape_fill_scanner.sv
// Framebuffer shape fill scanner: raster pixel walker with shape coverage test.
// Depends on fsfs_pkg (widths, shape mode and register index codes).
`default_nettype none

// Each accepted request transaction scans one pixel in raster order (restart
// in req_tdata bit 0 jumps to pixel zero) and yields one response transaction
// with the word index in the selected buffer, the column, the row, the
// coverage bit and the fill color; rsp_tlast marks the last pixel of the
// screen. The block takes one pixel per clock unless backpressure stalls it;
// a request reaches rsp_tvalid through four registers: a position register,
// a difference and edge-compare stage, a squaring stage (four parallel 15x15
// squarers and the 10x10 radius square) and the distance compare into the
// output register. Backpressure collapses bubbles stage by stage. Write
// configuration registers only while no pixel is in flight.
module framebuffer_shape_fill_scanner
   import fsfs_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 800,
   parameter int SCREEN_HEIGHT = 480
) (
   input  wire                      clock,
   input  wire                      reset,
   // request: [0] restart, [7:1] zero
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire  [REQ_TDATA_W-1:0]   req_tdata,
   // response: [19:0] pixel_index, [29:20] pixel_x, [38:30] pixel_y,
   // [39] covered, [71:40] color_out
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                     rsp_tlast,
   // configuration writes
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire  [CSR_INDEX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]    csr_data
);

   localparam int COL_W       = $clog2(SCREEN_WIDTH);
   localparam int ROW_W       = $clog2(SCREEN_HEIGHT);
   localparam int FRAME_WORDS = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int IDX_NEED    = $clog2(2 * FRAME_WORDS);
   localparam int IDX_W       = (IDX_NEED > PIXEL_INDEX_W) ? IDX_NEED : PIXEL_INDEX_W;
   localparam int XO_W        = (COL_W > PIXEL_X_W) ? COL_W : PIXEL_X_W;
   localparam int YO_W        = (ROW_W > PIXEL_Y_W) ? ROW_W : PIXEL_Y_W;
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   shape_mode_type              shape_mode_ff;
   logic [COLOR_W-1:0]          fill_color_ff;
   logic signed [ORIGIN_W-1:0]  origin_x_ff;
   logic signed [ORIGIN_W-1:0]  origin_y_ff;
   logic [SIZE_W-1:0]           box_width_ff;
   logic [SIZE_W-1:0]           box_height_ff;
   logic [RADIUS_W-1:0]         corner_radius_ff;
   logic                        buffer_select_ff;

   logic csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff    <= SHAPE_RECT;
         fill_color_ff    <= '0;
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         box_width_ff     <= '0;
         box_height_ff    <= '0;
         corner_radius_ff <= '0;
         buffer_select_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            REG_SHAPE_MODE:    shape_mode_ff    <= shape_mode_type'(csr_data[MODE_W-1:0]);
            REG_FILL_COLOR:    fill_color_ff    <= csr_data[COLOR_W-1:0];
            REG_ORIGIN_X:      origin_x_ff      <= csr_data[ORIGIN_W-1:0];
            REG_ORIGIN_Y:      origin_y_ff      <= csr_data[ORIGIN_W-1:0];
            REG_BOX_WIDTH:     box_width_ff     <= csr_data[SIZE_W-1:0];
            REG_BOX_HEIGHT:    box_height_ff    <= csr_data[SIZE_W-1:0];
            REG_CORNER_RADIUS: corner_radius_ff <= csr_data[RADIUS_W-1:0];
            REG_BUFFER_SELECT: buffer_select_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Shape geometry; user keeps configuration stable while busy (not enforced)
   // ---------------------------------------------------------------------
   logic [RADIUS_W-1:0]       half_height;
   logic                      big_radius;
   logic [RADIUS_W-1:0]       radius_eff;
   logic signed [GEOM_W-1:0]  g_ox, g_oy, g_w, g_h, g_r;
   logic signed [GEOM_W-1:0]  edge_xa, edge_xb, edge_xr;
   logic signed [GEOM_W-1:0]  edge_ya, edge_yb, edge_yd;

   always_comb begin
      half_height = box_height_ff[SIZE_W-1:1];
      big_radius  = corner_radius_ff >= half_height;
      if (shape_mode_ff == SHAPE_ROUNDED && big_radius) begin
         radius_eff = half_height;
      end else begin
         radius_eff = corner_radius_ff;
      end
      g_ox = GEOM_W'(origin_x_ff);
      g_oy = GEOM_W'(origin_y_ff);
      g_w  = GEOM_W'(box_width_ff);
      g_h  = GEOM_W'(box_height_ff);
      g_r  = GEOM_W'(radius_eff);
      // circle mode centers the first circle on the origin itself
      if (shape_mode_ff == SHAPE_CIRCLE) begin
         edge_xa = g_ox;
         edge_ya = g_oy;
      end else begin
         edge_xa = g_ox + g_r;
         edge_ya = g_oy + g_r;
      end
      edge_xr = g_ox + g_w;
      edge_xb = edge_xr - g_r;
      edge_yd = g_oy + g_h;
      edge_yb = edge_yd - g_r;
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------------
   logic st1_valid_ff, st2_valid_ff, st3_valid_ff, out_valid_ff;
   logic st1_load, st2_load, st3_load, out_load;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign st3_load   = !st3_valid_ff || out_load;
   assign st2_load   = !st2_valid_ff || st3_load;
   assign st1_load   = !st1_valid_ff || st2_load;
   assign req_tready = st1_load;

   logic req_accept;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (st1_load) st1_valid_ff <= req_tvalid;
         if (st2_load) st2_valid_ff <= st1_valid_ff;
         if (st3_load) st3_valid_ff <= st2_valid_ff;
         if (out_load) out_valid_ff <= st3_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Scan position and stage 1
   // ---------------------------------------------------------------------
   logic [COL_W-1:0] scan_col_ff, scan_col_in, cur_col;
   logic [ROW_W-1:0] scan_row_ff, scan_row_in, cur_row;
   logic [COL_W-1:0] st1_col_ff;
   logic [ROW_W-1:0] st1_row_ff;
   logic             st1_last_ff, st1_last_in;

   always_comb begin
      if (req_tdata[0]) begin
         cur_col = '0;
         cur_row = '0;
      end else begin
         cur_col = scan_col_ff;
         cur_row = scan_row_ff;
      end
      st1_last_in = (cur_col == LAST_COL) && (cur_row == LAST_ROW);
      if (cur_col == LAST_COL) begin
         scan_col_in = '0;
         scan_row_in = (cur_row == LAST_ROW) ? '0 : cur_row + 1'b1;
      end else begin
         scan_col_in = cur_col + 1'b1;
         scan_row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_col_ff <= '0;
         scan_row_ff <= '0;
      end else if (req_accept) begin
         scan_col_ff <= scan_col_in;
         scan_row_ff <= scan_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (st1_load) begin
         st1_col_ff  <= cur_col;
         st1_row_ff  <= cur_row;
         st1_last_ff <= st1_last_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: distances to centers, edge tests, word index
   // ---------------------------------------------------------------------
   logic signed [GEOM_W-1:0] px, py;
   logic signed [GEOM_W-1:0] st2_dx1_ff, st2_dx2_ff, st2_dy1_ff, st2_dy2_ff;
   logic [RADIUS_W-1:0]      st2_r_ff;
   logic st2_box_in, st2_left_in, st2_right_in, st2_centre_in;
   logic st2_box_ff, st2_left_ff, st2_right_ff, st2_centre_ff;
   logic [IDX_W-1:0]         st2_idx_in, st2_idx_ff;
   logic [COL_W-1:0]         st2_col_ff;
   logic [ROW_W-1:0]         st2_row_ff;
   logic                     st2_last_ff;

   always_comb begin
      px = GEOM_W'(st1_col_ff);
      py = GEOM_W'(st1_row_ff);
      st2_box_in    = (px >= g_ox) && (px < edge_xr) && (py >= g_oy) && (py < edge_yd);
      st2_left_in   = (px >= g_ox) && (px < edge_xa) && (py >= edge_ya) && (py < edge_yb);
      st2_right_in  = (px >= edge_xb) && (px < edge_xr) && (py >= edge_ya) && (py < edge_yb);
      st2_centre_in = (px >= edge_xa) && (px < edge_xb) && (py >= g_oy) && (py < edge_yd);
      st2_idx_in = IDX_W'(st1_row_ff) * IDX_W'(SCREEN_WIDTH) + IDX_W'(st1_col_ff);
      if (buffer_select_ff) begin
         st2_idx_in = st2_idx_in + IDX_W'(FRAME_WORDS);
      end
   end

   always_ff @(posedge clock) begin
      if (st2_load) begin
         st2_dx1_ff    <= px - edge_xa;
         st2_dx2_ff    <= px - edge_xb;
         st2_dy1_ff    <= py - edge_ya;
         st2_dy2_ff    <= py - edge_yb;
         st2_r_ff      <= radius_eff;
         st2_box_ff    <= st2_box_in;
         st2_left_ff   <= st2_left_in;
         st2_right_ff  <= st2_right_in;
         st2_centre_ff <= st2_centre_in;
         st2_idx_ff    <= st2_idx_in;
         st2_col_ff    <= st1_col_ff;
         st2_row_ff    <= st1_row_ff;
         st2_last_ff   <= st1_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: squares
   // ---------------------------------------------------------------------
   logic [SQ_W-1:0]  st3_dx1sq_ff, st3_dx2sq_ff, st3_dy1sq_ff, st3_dy2sq_ff;
   logic [RSQ_W-1:0] st3_rsq_ff;
   logic st3_box_ff, st3_left_ff, st3_right_ff, st3_centre_ff;
   logic [IDX_W-1:0] st3_idx_ff;
   logic [COL_W-1:0] st3_col_ff;
   logic [ROW_W-1:0] st3_row_ff;
   logic             st3_last_ff;

   always_ff @(posedge clock) begin
      if (st3_load) begin
         st3_dx1sq_ff  <= SQ_W'(SQ_W'(st2_dx1_ff) * SQ_W'(st2_dx1_ff));
         st3_dx2sq_ff  <= SQ_W'(SQ_W'(st2_dx2_ff) * SQ_W'(st2_dx2_ff));
         st3_dy1sq_ff  <= SQ_W'(SQ_W'(st2_dy1_ff) * SQ_W'(st2_dy1_ff));
         st3_dy2sq_ff  <= SQ_W'(SQ_W'(st2_dy2_ff) * SQ_W'(st2_dy2_ff));
         st3_rsq_ff    <= RSQ_W'(st2_r_ff) * RSQ_W'(st2_r_ff);
         st3_box_ff    <= st2_box_ff;
         st3_left_ff   <= st2_left_ff;
         st3_right_ff  <= st2_right_ff;
         st3_centre_ff <= st2_centre_ff;
         st3_idx_ff    <= st2_idx_ff;
         st3_col_ff    <= st2_col_ff;
         st3_row_ff    <= st2_row_ff;
         st3_last_ff   <= st2_last_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: circle tests and coverage select
   // ---------------------------------------------------------------------
   logic [SQ_W:0] rsq_ext;
   logic in_c11, in_c21, in_c12, in_c22;
   logic out_cov_in, out_cov_ff;
   logic [PIXEL_INDEX_W-1:0] out_idx_ff;
   logic [COL_W-1:0] out_col_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic             out_last_ff;

   always_comb begin
      rsq_ext = (SQ_W + 1)'(st3_rsq_ff);
      in_c11 = ((SQ_W + 1)'(st3_dx1sq_ff) + (SQ_W + 1)'(st3_dy1sq_ff)) <= rsq_ext;
      in_c21 = ((SQ_W + 1)'(st3_dx2sq_ff) + (SQ_W + 1)'(st3_dy1sq_ff)) <= rsq_ext;
      in_c12 = ((SQ_W + 1)'(st3_dx1sq_ff) + (SQ_W + 1)'(st3_dy2sq_ff)) <= rsq_ext;
      in_c22 = ((SQ_W + 1)'(st3_dx2sq_ff) + (SQ_W + 1)'(st3_dy2sq_ff)) <= rsq_ext;
      case (shape_mode_ff)
         SHAPE_RECT:   out_cov_in = st3_box_ff;
         SHAPE_CIRCLE: out_cov_in = in_c11;
         SHAPE_ROUNDED: begin
            // large radius keeps only the two top circles and the center strip
            if (big_radius) begin
               out_cov_in = in_c11 || in_c21 || st3_centre_ff;
            end else begin
               out_cov_in = in_c11 || in_c21 || in_c12 || in_c22 ||
                            st3_left_ff || st3_right_ff || st3_centre_ff;
            end
         end
         default: out_cov_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_cov_ff  <= out_cov_in;
         out_idx_ff  <= st3_idx_ff[PIXEL_INDEX_W-1:0];
         out_col_ff  <= st3_col_ff;
         out_row_ff  <= st3_row_ff;
         out_last_ff <= st3_last_ff;
      end
   end

   logic [XO_W-1:0] out_x_ext;
   logic [YO_W-1:0] out_y_ext;

   assign out_x_ext  = XO_W'(out_col_ff);
   assign out_y_ext  = YO_W'(out_row_ff);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {fill_color_ff, out_cov_ff, out_y_ext[PIXEL_Y_W-1:0],
                        out_x_ext[PIXEL_X_W-1:0], out_idx_ff};

`ifndef SYNTH
   // restart always lands the pixel at the origin of the screen
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tdata[0]) |=> (st1_col_ff == '0 && st1_row_ff == '0))
      else $error("restart did not scan pixel zero");

   // scan position never leaves the screen
   assert property (@(posedge clock) disable iff (reset)
      (scan_col_ff <= LAST_COL) && (scan_row_ff <= LAST_ROW))
      else $error("scan position out of range");

   // a stalled stage 1 entry holds its pixel
   assert property (@(posedge clock) disable iff (reset)
      (st1_valid_ff && !st2_load) |=>
         (st1_valid_ff && $stable(st1_col_ff) && $stable(st1_row_ff)))
      else $error("stage 1 pixel lost under backpressure");

   // the last-pixel flag goes only with the bottom-right corner
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_col_ff == LAST_COL && out_row_ff == LAST_ROW))
      else $error("last pixel flag on wrong position");

   // scan advances only on an accepted request
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(scan_col_ff) && $stable(scan_row_ff)))
      else $error("scan moved without a request");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for framebuffer_shape_fill_scanner: drives pixel scan requests and
// shape register writes, predicts every scanned pixel and checks each response.
// Depends on fsfs_pkg and the scanner RTL.

module tb;
   import fsfs_pkg::*;

   localparam int SCREEN_W      = 800;
   localparam int SCREEN_H      = 480;
   localparam int LATENCY       = 4;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int RANDOM_PIXELS = 1000;
   localparam int MAX_REPORTS   = 40;

   // shape_mode value with no shape behind it
   localparam logic [MODE_W-1:0] SHAPE_UNUSED = 2'd3;

   // response tdata layout
   localparam int X_LSB     = PIXEL_INDEX_W;
   localparam int Y_LSB     = X_LSB + PIXEL_X_W;
   localparam int COV_BIT   = Y_LSB + PIXEL_Y_W;
   localparam int COLOR_LSB = COV_BIT + 1;

   typedef struct {
      logic [PIXEL_INDEX_W-1:0] index;
      logic [PIXEL_X_W-1:0]     x;
      logic [PIXEL_Y_W-1:0]     y;
      logic                     covered;
      logic [COLOR_W-1:0]       color;
      logic                     last;
   } pixel_result_type;

   typedef struct {
      logic [MODE_W-1:0]          mode;
      logic [COLOR_W-1:0]         color;
      logic signed [ORIGIN_W-1:0] origin_x;
      logic signed [ORIGIN_W-1:0] origin_y;
      logic [SIZE_W-1:0]          width;
      logic [SIZE_W-1:0]          height;
      logic [RADIUS_W-1:0]        radius;
      logic                       buf_sel;
   } shape_regs_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   shape_regs_type          shape_regs;
   logic [PIXEL_X_W-1:0]    scan_col;
   logic [PIXEL_Y_W-1:0]    scan_row;
   pixel_result_type        pending_pixels[$];
   int                      mismatch_count = 0;
   longint                  cycle_count = 0;
   bit                      throttle_rx = 1'b1;

   framebuffer_shape_fill_scanner #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit in_box(longint x, longint y, longint rx, longint ry,
                                 longint rw, longint rh);
      return x >= rx && x < rx + rw && y >= ry && y < ry + rh;
   endfunction

   function automatic bit in_disc(longint x, longint y, longint cx, longint cy,
                                  longint r);
      longint dx, dy;
      dx = x - cx;
      dy = y - cy;
      return dx * dx + dy * dy <= r * r;
   endfunction

   function automatic bit shape_covers(longint x, longint y);
      longint ox, oy, w, h, r;
      bit     hit;
      ox = shape_regs.origin_x;
      oy = shape_regs.origin_y;
      w  = shape_regs.width;
      h  = shape_regs.height;
      r  = shape_regs.radius;
      case (shape_regs.mode)
         SHAPE_RECT:   return in_box(x, y, ox, oy, w, h);
         SHAPE_CIRCLE: return in_disc(x, y, ox, oy, r);
         SHAPE_ROUNDED: begin
            // clamp a tall radius and keep only the two top corners and the center strip
            if (r >= h / 2) begin
               r = h / 2;
               hit = in_disc(x, y, ox + r, oy + r, r) ||
                     in_disc(x, y, ox + w - r, oy + r, r);
            end else begin
               hit = in_disc(x, y, ox + r, oy + r, r) ||
                     in_disc(x, y, ox + w - r, oy + r, r) ||
                     in_disc(x, y, ox + r, oy + h - r, r) ||
                     in_disc(x, y, ox + w - r, oy + h - r, r) ||
                     in_box(x, y, ox, oy + r, r, h - 2 * r) ||
                     in_box(x, y, ox + w - r, oy + r, r, h - 2 * r);
            end
            return hit || in_box(x, y, ox + r, oy, w - 2 * r, h);
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic pixel_result_type scan_next_pixel(bit restart);
      pixel_result_type     px;
      logic [PIXEL_X_W-1:0] col;
      logic [PIXEL_Y_W-1:0] row;
      longint               word;
      col = restart ? '0 : scan_col;
      row = restart ? '0 : scan_row;
      word = longint'(shape_regs.buf_sel) * SCREEN_W * SCREEN_H +
             longint'(row) * SCREEN_W + longint'(col);
      px.index   = word[PIXEL_INDEX_W-1:0];
      px.x       = col;
      px.y       = row;
      px.covered = shape_covers(longint'(col), longint'(row));
      px.color   = shape_regs.color;
      px.last    = (int'(col) == SCREEN_W - 1) && (int'(row) == SCREEN_H - 1);
      // advance in raster order, wrap after the last pixel
      if (int'(col) == SCREEN_W - 1) begin
         col = '0;
         row = (int'(row) == SCREEN_H - 1) ? '0 : row + 1'b1;
      end else begin
         col = col + 1'b1;
      end
      scan_col = col;
      scan_row = row;
      return px;
   endfunction

   function automatic shape_regs_type make_shape(logic [MODE_W-1:0] mode,
                                                 logic [COLOR_W-1:0] color,
                                                 int ox, int oy, int w, int h,
                                                 int r, bit buf_sel);
      shape_regs_type s;
      s.mode     = mode;
      s.color    = color;
      s.origin_x = ORIGIN_W'(ox);
      s.origin_y = ORIGIN_W'(oy);
      s.width    = SIZE_W'(w);
      s.height   = SIZE_W'(h);
      s.radius   = RADIUS_W'(r);
      s.buf_sel  = buf_sel;
      return s;
   endfunction

   // --------------------------------------------------------------- checking

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_REPORTS)
         $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch($sformatf("response with nothing pending, tdata %0h",
                                      rsp_tdata));
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[0 +: PIXEL_INDEX_W] !== want.index)
               report_mismatch($sformatf("pixel (%0d,%0d) index %0d, expected %0d",
                  want.x, want.y, rsp_tdata[0 +: PIXEL_INDEX_W], want.index));
            if (rsp_tdata[X_LSB +: PIXEL_X_W] !== want.x)
               report_mismatch($sformatf("pixel (%0d,%0d) x %0d", want.x, want.y,
                  rsp_tdata[X_LSB +: PIXEL_X_W]));
            if (rsp_tdata[Y_LSB +: PIXEL_Y_W] !== want.y)
               report_mismatch($sformatf("pixel (%0d,%0d) y %0d", want.x, want.y,
                  rsp_tdata[Y_LSB +: PIXEL_Y_W]));
            if (rsp_tdata[COV_BIT] !== want.covered)
               report_mismatch($sformatf("pixel (%0d,%0d) covered %b, expected %b",
                  want.x, want.y, rsp_tdata[COV_BIT], want.covered));
            if (rsp_tdata[COLOR_LSB +: COLOR_W] !== want.color)
               report_mismatch($sformatf("pixel (%0d,%0d) color %h, expected %h",
                  want.x, want.y, rsp_tdata[COLOR_LSB +: COLOR_W], want.color));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("pixel (%0d,%0d) tlast %b, expected %b",
                  want.x, want.y, rsp_tlast, want.last));
         end
      end
   end

   // receiver: spans of steady ready and spans of random stalls, picked at random
   initial begin
      int span;
      bit calm;
      rsp_tready = 1'b1;
      forever begin
         span = $urandom_range(1, 40);
         calm = ($urandom_range(0, 3) == 0);
         repeat (span) begin
            @(negedge clock);
            rsp_tready = (!throttle_rx || calm) ? 1'b1 : ($urandom_range(0, 9) > 3);
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   // Called at a falling edge; returns at the falling edge after acceptance
   // with tvalid still high.
   task automatic send_pixel(bit restart);
      req_tdata  = {{(REQ_TDATA_W-1){1'b0}}, restart};
      req_tvalid = 1'b1;
      pending_pixels.push_back(scan_next_pixel(restart));
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      req_tvalid = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // drop the request, let every pixel drain, then let the pipe go quiet
   task automatic settle();
      req_tvalid = 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [CSR_DATA_W-1:0] value);
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SHAPE_MODE:    shape_regs.mode     = value[MODE_W-1:0];
         REG_FILL_COLOR:    shape_regs.color    = value[COLOR_W-1:0];
         REG_ORIGIN_X:      shape_regs.origin_x = value[ORIGIN_W-1:0];
         REG_ORIGIN_Y:      shape_regs.origin_y = value[ORIGIN_W-1:0];
         REG_BOX_WIDTH:     shape_regs.width    = value[SIZE_W-1:0];
         REG_BOX_HEIGHT:    shape_regs.height   = value[SIZE_W-1:0];
         REG_CORNER_RADIUS: shape_regs.radius   = value[RADIUS_W-1:0];
         REG_BUFFER_SELECT: shape_regs.buf_sel  = value[0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // junk fills the register bits above each field
   task automatic load_shape(shape_regs_type s, logic [CSR_DATA_W-1:0] junk);
      write_reg(REG_SHAPE_MODE,    {junk[CSR_DATA_W-1:MODE_W], s.mode});
      write_reg(REG_FILL_COLOR,    s.color);
      write_reg(REG_ORIGIN_X,      {junk[CSR_DATA_W-1:ORIGIN_W], s.origin_x});
      write_reg(REG_ORIGIN_Y,      {junk[CSR_DATA_W-1:ORIGIN_W], s.origin_y});
      write_reg(REG_BOX_WIDTH,     {junk[CSR_DATA_W-1:SIZE_W], s.width});
      write_reg(REG_BOX_HEIGHT,    {junk[CSR_DATA_W-1:SIZE_W], s.height});
      write_reg(REG_CORNER_RADIUS, {junk[CSR_DATA_W-1:RADIUS_W], s.radius});
      write_reg(REG_BUFFER_SELECT, {junk[CSR_DATA_W-1:1], s.buf_sel});
      csr_valid = 1'b0;
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_reset_state();
      send_pixel(1'b0);
      send_pixel(1'b0);
   endtask

   task automatic test_rectangle();
      settle();
      load_shape(make_shape(SHAPE_RECT, 32'hFFFF_FFFF, 1, 0, 3, 1, 0, 1'b1), '0);
      send_pixel(1'b1);
      repeat (4) send_pixel(1'b0);
      // box ends one column left of the screen
      settle();
      load_shape(make_shape(SHAPE_RECT, 32'h0, -2048, -2048, 2047, 2047, 0, 1'b0), '1);
      send_pixel(1'b1);
   endtask

   task automatic test_circle();
      settle();
      load_shape(make_shape(SHAPE_CIRCLE, 32'h00FF_00FF, 2, 0, 0, 0, 1, 1'b0), '0);
      send_pixel(1'b1);
      repeat (4) send_pixel(1'b0);
      // zero radius still covers its center
      settle();
      load_shape(make_shape(SHAPE_CIRCLE, 32'hFF00_FF00, 0, 0, 0, 0, 0, 1'b1), '0);
      send_pixel(1'b1);
      settle();
      load_shape(make_shape(SHAPE_CIRCLE, 32'h1234_5678, 2047, 2047, 0, 0, 1023, 1'b0), '0);
      send_pixel(1'b1);
   endtask

   task automatic test_rounded_rectangle();
      settle();
      load_shape(make_shape(SHAPE_ROUNDED, 32'hA5A5_5A5A, 0, 0, 6, 8, 2, 1'b0), '0);
      send_pixel(1'b1);
      repeat (5) send_pixel(1'b0);
      // radius clamps to half the height
      settle();
      load_shape(make_shape(SHAPE_ROUNDED, 32'h0F0F_F0F0, 0, 0, 10, 4, 1023, 1'b1), '0);
      send_pixel(1'b1);
      send_pixel(1'b0);
      // center strip of negative width
      settle();
      load_shape(make_shape(SHAPE_ROUNDED, 32'h8000_0001, 0, -3, 2, 20, 3, 1'b0), '0);
      send_pixel(1'b1);
   endtask

   task automatic test_unused_mode();
      settle();
      load_shape(make_shape(SHAPE_UNUSED, 32'hDEAD_BEEF, 0, 0, 2047, 2047, 1023, 1'b1),
                 '0);
      send_pixel(1'b1);
   endtask

   // scan one whole row at full rate and wrap onto the next row
   task automatic test_row_wrap();
      settle();
      load_shape(make_shape(SHAPE_ROUNDED, 32'hC0FF_EE00, 100, -50, 300, 200, 40, 1'b1),
                 '0);
      throttle_rx = 1'b0;
      send_pixel(1'b1);
      repeat (SCREEN_W + 1) send_pixel(1'b0);
      settle();
      throttle_rx = 1'b1;
   endtask

   // shapes land mostly around the pixels about to be scanned
   function automatic shape_regs_type random_shape();
      shape_regs_type s;
      int             pick;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         s.mode = SHAPE_UNUSED;
      else if (pick < 7)
         s.mode = SHAPE_RECT;
      else if (pick < 13)
         s.mode = SHAPE_CIRCLE;
      else
         s.mode = SHAPE_ROUNDED;
      s.color   = $urandom();
      s.buf_sel = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
         s.origin_x = ORIGIN_W'($urandom());
         s.origin_y = ORIGIN_W'($urandom());
         s.width    = ($urandom_range(0, 3) == 0) ? '1 : SIZE_W'($urandom());
         s.height   = ($urandom_range(0, 3) == 0) ? '1 : SIZE_W'($urandom());
         s.radius   = ($urandom_range(0, 3) == 0) ? '1 : RADIUS_W'($urandom());
      end else begin
         s.origin_x = ORIGIN_W'(int'(scan_col) + int'($urandom_range(0, 80)) - 30);
         s.origin_y = ORIGIN_W'(int'(scan_row) + int'($urandom_range(0, 8)) - 4);
         s.width    = SIZE_W'($urandom_range(0, 60));
         s.height   = SIZE_W'($urandom_range(0, 12));
         s.radius   = RADIUS_W'($urandom_range(0, 8));
      end
      return s;
   endfunction

   task automatic test_random_shapes();
      int sent;
      int burst;
      sent = 0;
      while (sent < RANDOM_PIXELS) begin
         settle();
         load_shape(random_shape(), $urandom_range(0, 1) ? $urandom() : '0);
         burst = 0;
         repeat ($urandom_range(20, 70)) begin
            if (burst == 0) begin
               burst = $urandom_range(1, 24);
               if ($urandom_range(0, 2) != 0)
                  pause_sender($urandom_range(1, 6));
            end
            send_pixel($urandom_range(0, 59) == 0);
            burst--;
            sent++;
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = REG_SHAPE_MODE;
      csr_data   = '0;
      shape_regs = make_shape(SHAPE_RECT, 32'h0, 0, 0, 0, 0, 0, 1'b0);
      scan_col   = '0;
      scan_row   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_rectangle();
      test_circle();
      test_rounded_rectangle();
      test_unused_mode();
      test_row_wrap();
      test_random_shapes();

      settle();
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
